@@ hw/rtl/msgpack_record_frame_encoder_assert.svh @@
// Assertion macros shared by the record frame encoder RTL.
// Depends on nothing; included by the top level where its checks are written.
`ifndef MSGPACK_RECORD_FRAME_ENCODER_ASSERT_SVH
`define MSGPACK_RECORD_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked later than the antecedent.
`define MRFE_ASSERT_LATER2(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> ##2 (cons)) else $error(msg);

`endif

@@ hw/rtl/mrfe_pkg.sv @@
// Shared types, constants and encoding helpers of the record frame encoder.
// Depends on nothing; imported by every module of the block.
package mrfe_pkg;

    localparam int unsigned MRFE_Q_DEPTH = 2;
    localparam int unsigned MRFE_QPTR_W  = (MRFE_Q_DEPTH > 1) ? $clog2(MRFE_Q_DEPTH) : 1;
    localparam int unsigned MRFE_QCNT_W  = $clog2(MRFE_Q_DEPTH + 1);
    localparam int unsigned MRFE_IDX_W   = 4;
    localparam int unsigned MRFE_PLEN_W  = 5;

    localparam logic [7:0] MRFE_FIXARRAY4 = 8'h94;
    localparam logic [7:0] MRFE_PFX_U8    = 8'hcc;
    localparam logic [7:0] MRFE_PFX_U16   = 8'hcd;
    localparam logic [7:0] MRFE_PFX_U32   = 8'hce;
    localparam logic [7:0] MRFE_PFX_U64   = 8'hcf;

    localparam logic [1:0] FLD_PID  = 2'd0;
    localparam logic [1:0] FLD_GID  = 2'd1;
    localparam logic [1:0] FLD_CPU  = 2'd2;
    localparam logic [1:0] FLD_TIME = 2'd3;

    localparam logic [MRFE_IDX_W-1:0] LEN_LAST_IDX = MRFE_IDX_W'(3);

    typedef enum logic [2:0] {
        CLS_FIX,
        CLS_U8,
        CLS_U16,
        CLS_U32,
        CLS_U64
    } t_ucls;

    typedef enum logic [1:0] {
        SEG_LEN,
        SEG_HDR,
        SEG_FIELD
    } t_seg;

    typedef struct packed {
        logic [31:0]            process_id;
        logic [31:0]            group_id;
        logic [31:0]            cpu_number;
        logic [63:0]            time_value;
        t_ucls                  cls_pid;
        t_ucls                  cls_gid;
        t_ucls                  cls_cpu;
        t_ucls                  cls_time;
        logic [MRFE_PLEN_W-1:0] payload_len;
    } t_rec;

    typedef struct packed {
        logic                   valid;
        logic                   full;
        logic [MRFE_QCNT_W-1:0] count;
        t_rec                   rec;
    } t_qhead;

    // Shortest unsigned form of a value.
    function automatic t_ucls classify(input logic [63:0] v);
        t_ucls c;
        if (v[63:32] != 32'd0) begin
            c = CLS_U64;
        end else if (v[31:16] != 16'd0) begin
            c = CLS_U32;
        end else if (v[15:8] != 8'd0) begin
            c = CLS_U16;
        end else if (v[7] != 1'b0) begin
            c = CLS_U8;
        end else begin
            c = CLS_FIX;
        end
        return c;
    endfunction

    // Encoded length in bytes, prefix included.
    function automatic logic [MRFE_IDX_W-1:0] cls_len(input t_ucls c);
        logic [MRFE_IDX_W-1:0] n;
        unique case (c)
            CLS_FIX: n = MRFE_IDX_W'(1);
            CLS_U8:  n = MRFE_IDX_W'(2);
            CLS_U16: n = MRFE_IDX_W'(3);
            CLS_U32: n = MRFE_IDX_W'(5);
            CLS_U64: n = MRFE_IDX_W'(9);
            default: n = MRFE_IDX_W'(1);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] cls_prefix(input t_ucls c);
        logic [7:0] p;
        unique case (c)
            CLS_U8:  p = MRFE_PFX_U8;
            CLS_U16: p = MRFE_PFX_U16;
            CLS_U32: p = MRFE_PFX_U32;
            CLS_U64: p = MRFE_PFX_U64;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/mrfe_front.sv @@
// Front end: takes records, sizes each value and the payload, pushes the result.
// Depends on mrfe_pkg.
module mrfe_front
    import mrfe_pkg::*;
(
    input  logic        i_start,
    input  logic        i_full,
    input  logic [31:0] i_process_id,
    input  logic [31:0] i_group_id,
    input  logic [31:0] i_cpu_number,
    input  logic [63:0] i_time_value,
    output logic        o_busy,
    output logic        o_push,
    output t_rec        o_rec
);

    t_ucls c_pid;
    t_ucls c_gid;
    t_ucls c_cpu;
    t_ucls c_time;

    always_comb begin
        c_pid  = classify({32'd0, i_process_id});
        c_gid  = classify({32'd0, i_group_id});
        c_cpu  = classify({32'd0, i_cpu_number});
        c_time = classify(i_time_value);

        o_rec.process_id  = i_process_id;
        o_rec.group_id    = i_group_id;
        o_rec.cpu_number  = i_cpu_number;
        o_rec.time_value  = i_time_value;
        o_rec.cls_pid     = c_pid;
        o_rec.cls_gid     = c_gid;
        o_rec.cls_cpu     = c_cpu;
        o_rec.cls_time    = c_time;
        // The array header byte plus the four encoded values.
        o_rec.payload_len = MRFE_PLEN_W'(1)
                          + MRFE_PLEN_W'(cls_len(c_pid))
                          + MRFE_PLEN_W'(cls_len(c_gid))
                          + MRFE_PLEN_W'(cls_len(c_cpu))
                          + MRFE_PLEN_W'(cls_len(c_time));
    end

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

endmodule

@@ hw/rtl/mrfe_fifo.sv @@
// Short queue of sized records between the front end and the byte serializer.
// Depends on mrfe_pkg.
module mrfe_fifo
    import mrfe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_rec   i_rec,
    input  logic   i_pop,
    output t_qhead o_head
);

    t_rec                   r_mem [MRFE_Q_DEPTH];
    logic [MRFE_QPTR_W-1:0] r_wptr;
    logic [MRFE_QPTR_W-1:0] r_rptr;
    logic [MRFE_QCNT_W-1:0] r_count;
    logic [MRFE_QPTR_W-1:0] n_wptr;
    logic [MRFE_QPTR_W-1:0] n_rptr;
    logic [MRFE_QCNT_W-1:0] n_count;

    function automatic logic [MRFE_QPTR_W-1:0] ptr_inc(input logic [MRFE_QPTR_W-1:0] p);
        logic [MRFE_QPTR_W-1:0] q;
        if (p == MRFE_QPTR_W'(MRFE_Q_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + MRFE_QPTR_W'(1);
        end
        return q;
    endfunction

    always_comb begin
        n_wptr  = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr  = i_pop ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count + MRFE_QCNT_W'(i_push) - MRFE_QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    always_comb begin
        o_head.valid = (r_count != '0);
        o_head.full  = (r_count == MRFE_QCNT_W'(MRFE_Q_DEPTH));
        o_head.count = r_count;
        o_head.rec   = r_mem[r_rptr];
    end

endmodule

@@ hw/rtl/mrfe_back.sv @@
// Back end: walks the frame of the head record and sends one byte per cycle while the queue holds a record.
// Depends on mrfe_pkg.
module mrfe_back
    import mrfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qhead     i_head,
    output logic       o_pop,
    output logic       o_strobe,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_end
);

    t_seg                  r_seg;
    t_seg                  n_seg;
    logic [1:0]            r_fld;
    logic [1:0]            n_fld;
    logic [MRFE_IDX_W-1:0] r_idx;
    logic [MRFE_IDX_W-1:0] n_idx;
    logic                  r_strobe;
    logic [7:0]            r_byte;
    logic                  r_end;

    logic [63:0]           fld_val;
    t_ucls                 fld_cls;
    logic [MRFE_IDX_W-1:0] fld_len;
    logic [MRFE_IDX_W-1:0] byte_pos;
    logic                  fld_last;
    logic [7:0]            c_byte;
    logic                  c_end;

    // Value and size class of the field under way.
    always_comb begin
        unique case (r_fld)
            FLD_PID: begin
                fld_val = {32'd0, i_head.rec.process_id};
                fld_cls = i_head.rec.cls_pid;
            end
            FLD_GID: begin
                fld_val = {32'd0, i_head.rec.group_id};
                fld_cls = i_head.rec.cls_gid;
            end
            FLD_CPU: begin
                fld_val = {32'd0, i_head.rec.cpu_number};
                fld_cls = i_head.rec.cls_cpu;
            end
            default: begin
                fld_val = i_head.rec.time_value;
                fld_cls = i_head.rec.cls_time;
            end
        endcase
        fld_len  = cls_len(fld_cls);
        fld_last = (r_idx == fld_len - MRFE_IDX_W'(1));
        // Data bytes go out most significant first after the prefix byte.
        byte_pos = fld_len - MRFE_IDX_W'(1) - r_idx;
    end

    // Next state.
    always_comb begin
        n_seg = r_seg;
        n_fld = r_fld;
        n_idx = r_idx;
        if (i_head.valid) begin
            unique case (r_seg)
                SEG_LEN: begin
                    if (r_idx == LEN_LAST_IDX) begin
                        n_seg = SEG_HDR;
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + MRFE_IDX_W'(1);
                    end
                end
                SEG_HDR: begin
                    n_seg = SEG_FIELD;
                    n_fld = FLD_PID;
                    n_idx = '0;
                end
                SEG_FIELD: begin
                    if (fld_last) begin
                        n_idx = '0;
                        if (r_fld == FLD_TIME) begin
                            n_seg = SEG_LEN;
                            n_fld = FLD_PID;
                        end else begin
                            n_fld = r_fld + 2'd1;
                        end
                    end else begin
                        n_idx = r_idx + MRFE_IDX_W'(1);
                    end
                end
                default: begin
                    n_seg = SEG_LEN;
                    n_fld = FLD_PID;
                    n_idx = '0;
                end
            endcase
        end
    end

    // Byte and end flag for the current position.
    always_comb begin
        c_byte = 8'h00;
        c_end  = 1'b0;
        unique case (r_seg)
            SEG_LEN: begin
                if (r_idx == LEN_LAST_IDX) begin
                    c_byte = 8'(i_head.rec.payload_len);
                end
            end
            SEG_HDR: begin
                c_byte = MRFE_FIXARRAY4;
            end
            SEG_FIELD: begin
                if (fld_cls == CLS_FIX) begin
                    c_byte = fld_val[7:0];
                end else if (r_idx == '0) begin
                    c_byte = cls_prefix(fld_cls);
                end else begin
                    c_byte = fld_val[{byte_pos[2:0], 3'b000} +: 8];
                end
                c_end = fld_last && (r_fld == FLD_TIME);
            end
            default: begin
                c_byte = 8'h00;
            end
        endcase
    end

    assign o_pop = i_head.valid && c_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg    <= SEG_LEN;
            r_fld    <= FLD_PID;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_seg    <= n_seg;
            r_fld    <= n_fld;
            r_idx    <= n_idx;
            r_strobe <= i_head.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= c_byte;
        r_end  <= c_end;
    end

    assign o_strobe     = r_strobe;
    assign o_frame_byte = r_byte;
    assign o_frame_end  = r_end && r_strobe;

endmodule

@@ hw/rtl/msgpack_record_frame_encoder.sv @@
// Top level of the MessagePack record frame encoder.
// Depends on mrfe_pkg, mrfe_front, mrfe_fifo, mrfe_back and the assertion header.
//
// Usage:
// A record (process id, group id, cpu number, 64-bit time) is presented on the
// i_ value ports and taken at a rising edge where start is high and busy is low.
// Each record becomes one frame: a 4-byte big-endian payload length, the fixarray
// header 0x94, and the four values in their shortest unsigned MessagePack form.
// The frame leaves one byte per cycle on o_frame_byte, marked by o_strobe, with
// o_frame_end high on its last byte. The receiver takes every strobed byte and
// cannot stall the output.
// When the serializer is idle, a taken record is first written into the queue,
// and its first byte passes through the serializer's output register before it
// appears. A frame is 9 to 29 bytes, and frames follow one another with no gap
// while the queue holds records.
// A two-record queue sits between the sizing front end and the serializer, so
// new records are taken while a frame is still going out; busy is high only
// while that queue is full.
// Reset (synchronous, active low) empties the queue and returns the serializer
// to the start of a frame; no byte is strobed in the cycle after reset.
`include "msgpack_record_frame_encoder_assert.svh"

module msgpack_record_frame_encoder
    import mrfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_process_id,
    input  logic [31:0] i_group_id,
    input  logic [31:0] i_cpu_number,
    input  logic [63:0] i_time_value,
    output logic        o_strobe,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end
);

    t_rec   s_rec;
    t_qhead s_head;
    logic   s_push;
    logic   s_pop;

    // Front end: sizes every value and the payload of the record as it arrives.
    mrfe_front u_front (
        .i_start      (start),
        .i_full       (s_head.full),
        .i_process_id (i_process_id),
        .i_group_id   (i_group_id),
        .i_cpu_number (i_cpu_number),
        .i_time_value (i_time_value),
        .o_busy       (busy),
        .o_push       (s_push),
        .o_rec        (s_rec)
    );

    // Queue of sized records; the serializer pops on the last byte of a frame.
    mrfe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_rec   (s_rec),
        .i_pop   (s_pop),
        .o_head  (s_head)
    );

    // Serializer: walks length prefix, header and the four fields byte by byte.
    mrfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (s_head),
        .o_pop        (s_pop),
        .o_strobe     (o_strobe),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end)
    );

    // The end flag only ever rides on a strobed byte.
    `MRFE_ASSERT_NOW(a_end_with_strobe, i_clk, i_rst_n, o_frame_end, o_strobe, "frame end without strobe")

    // Busy means the queue is full, nothing else.
    `MRFE_ASSERT_NOW(a_busy_full, i_clk, i_rst_n, busy, s_head.count == MRFE_QCNT_W'(MRFE_Q_DEPTH), "busy while queue has room")

    // A record taken into an empty queue starts its frame: its first byte is registered and strobed.
    `MRFE_ASSERT_LATER2(a_first_byte, i_clk, i_rst_n, s_push && !s_head.valid, o_strobe && !o_frame_end, "frame did not start after accept")

endmodule

@@ tb/sv/msgpack_record_frame_encoder_tb.sv @@
// Self-checking testbench for the MessagePack record frame encoder.
// Depends on mrfe_pkg for the format's header and prefix bytes, and on the RTL
// top level msgpack_record_frame_encoder; it predicts every frame byte in place.
module msgpack_record_frame_encoder_tb;
    import mrfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One input record as the block takes it.
    typedef struct packed {
        logic [31:0] process_id;
        logic [31:0] group_id;
        logic [31:0] cpu_number;
        logic [63:0] time_value;
    } t_record;

    // One expected output byte with its end-of-frame flag.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_byte;

    localparam int RANDOM_RECORDS = 450;
    localparam int DRAIN_CYCLES   = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_process_id;
    logic [31:0] i_group_id;
    logic [31:0] i_cpu_number;
    logic [63:0] i_time_value;
    logic        o_strobe;
    logic [7:0]  o_frame_byte;
    logic        o_frame_end;

    t_record     pending_records[$];   // records still to be offered to the block
    t_frame_byte exp_frame_q[$];       // predicted bytes, oldest first
    logic [7:0]  payload_bytes[$];     // scratch area for the frame being predicted

    int error_count    = 0;
    int records_taken  = 0;
    int bytes_checked  = 0;
    int frames_checked = 0;
    int gap_left       = 0;
    int burst_left     = 4;

    msgpack_record_frame_encoder u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_process_id (i_process_id),
        .i_group_id   (i_group_id),
        .i_cpu_number (i_cpu_number),
        .i_time_value (i_time_value),
        .o_strobe     (o_strobe),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Prints one line per mismatch (the first 30) and counts all of them.
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 30) begin
            $display("%0t ns mismatch: %s", $time, what);
        end
    endtask

    // Appends one byte to the end of the payload being built.
    function automatic void add_payload_byte(input logic [7:0] b);
        payload_bytes.insert(payload_bytes.size(), b);
    endfunction

    // Appends one predicted byte to the end of the expected stream.
    function automatic void add_expected(input t_frame_byte fb);
        exp_frame_q.insert(exp_frame_q.size(), fb);
    endfunction

    // Appends the shortest unsigned encoding of a value to the payload being built:
    // a positive fixint up to 0x7f, otherwise a width prefix and 1, 2, 4 or 8
    // big-endian bytes.
    function automatic void append_uint(input logic [63:0] v);
        int         nbytes;
        logic [7:0] prefix;
        if (v <= 64'h7f) begin
            add_payload_byte(v[7:0]);
            return;
        end
        if (v <= 64'hff) begin
            nbytes = 1;
            prefix = MRFE_PFX_U8;
        end else if (v <= 64'hffff) begin
            nbytes = 2;
            prefix = MRFE_PFX_U16;
        end else if (v <= 64'hffff_ffff) begin
            nbytes = 4;
            prefix = MRFE_PFX_U32;
        end else begin
            nbytes = 8;
            prefix = MRFE_PFX_U64;
        end
        add_payload_byte(prefix);
        for (int k = nbytes - 1; k >= 0; k--) begin
            add_payload_byte(v[8*k +: 8]);
        end
    endfunction

    // Builds the whole frame of one record and queues it byte by byte. The
    // four-byte length prefix counts only the payload, header byte included.
    function automatic void predict_frame(input t_record r);
        logic [31:0] payload_len;
        t_frame_byte fb;
        payload_bytes.delete();
        add_payload_byte(MRFE_FIXARRAY4);
        append_uint({32'd0, r.process_id});
        append_uint({32'd0, r.group_id});
        append_uint({32'd0, r.cpu_number});
        append_uint(r.time_value);
        payload_len = payload_bytes.size();
        // A frame is at least nine bytes, so the prefix never carries the end flag.
        for (int k = 3; k >= 0; k--) begin
            fb.value = payload_len[8*k +: 8];
            fb.last  = 1'b0;
            add_expected(fb);
        end
        foreach (payload_bytes[k]) begin
            fb.value = payload_bytes[k];
            fb.last  = (k == payload_bytes.size() - 1);
            add_expected(fb);
        end
    endfunction

    function automatic void add_record(input logic [31:0] pid, input logic [31:0] gid,
                                       input logic [31:0] cpu, input logic [63:0] tv);
        t_record r;
        r.process_id = pid;
        r.group_id   = gid;
        r.cpu_number = cpu;
        r.time_value = tv;
        pending_records.insert(pending_records.size(), r);
    endfunction

    // A random 32-bit value. Most picks choose an encoding width first so that
    // every width shows up often; some land on the width boundaries, and some
    // are plain random words.
    function automatic logic [31:0] random_word();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = $urandom_range(0, 32'h7f);
            1: v = $urandom_range(32'h80, 32'hff);
            2: v = $urandom_range(32'h100, 32'hffff);
            3, 4: v = $urandom_range(32'h1_0000, 32'hffff_ffff);
            5: begin
                case ($urandom_range(0, 7))
                    0: v = 32'h0;
                    1: v = 32'h7f;
                    2: v = 32'h80;
                    3: v = 32'hff;
                    4: v = 32'h100;
                    5: v = 32'hffff;
                    6: v = 32'h1_0000;
                    default: v = 32'hffff_ffff;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // A random time: any of the five widths, with the step from four to eight
    // bytes hit on purpose now and then.
    function automatic logic [63:0] random_time();
        logic [31:0] hi;
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = {32'd0, random_word()};
            2: v = {32'd0, 32'hffff_ffff};
            3: v = 64'h1_0000_0000;
            default: begin
                hi = $urandom;
                if (hi == 32'd0) begin
                    hi = 32'd1;
                end
                v = {hi, 32'($urandom)};
            end
        endcase
        return v;
    endfunction

    // Driver. Records are offered in bursts of random length separated by random
    // gaps; about one burst in four follows the previous one with no gap at all.
    // A record stays on the ports until an edge sees start high and busy low, and
    // the prediction is made at that same edge from the values being taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_frame({i_process_id, i_group_id, i_cpu_number, i_time_value});
                records_taken++;
            end
            if (start && busy) begin
                // Held off by a full queue: keep the same record presented.
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_records.size() != 0) begin
                t_record r;
                r = pending_records.pop_front();
                i_process_id <= r.process_id;
                i_group_id   <= r.group_id;
                i_cpu_number <= r.cpu_number;
                i_time_value <= r.time_value;
                start        <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 35);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor. The receiver cannot stall the block, so every strobed byte is
    // taken and compared with the oldest predicted byte, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (exp_frame_q.size() == 0) begin
                report_mismatch($sformatf("byte 0x%02h strobed with nothing expected",
                                          o_frame_byte));
            end else begin
                t_frame_byte fb;
                fb = exp_frame_q.pop_front();
                if (o_frame_byte !== fb.value) begin
                    report_mismatch($sformatf("frame byte 0x%02h, expected 0x%02h",
                                              o_frame_byte, fb.value));
                end
                if (o_frame_end !== fb.last) begin
                    report_mismatch($sformatf("frame end %b, expected %b on byte 0x%02h",
                                              o_frame_end, fb.last, fb.value));
                end
                bytes_checked++;
                if (fb.last) begin
                    frames_checked++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_process_id = 32'd0;
        i_group_id   = 32'd0;
        i_cpu_number = 32'd0;
        i_time_value = 64'd0;

        // Directed records: the shortest and the longest frame, every width
        // boundary on all four fields, the time crossing into eight bytes, and a
        // few mixed records whose fields take different widths.
        add_record(32'h0, 32'h0, 32'h0, 64'h0);
        add_record(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
        add_record(32'h7f, 32'h7f, 32'h7f, 64'h7f);
        add_record(32'h80, 32'h80, 32'h80, 64'h80);
        add_record(32'hff, 32'hff, 32'hff, 64'hff);
        add_record(32'h100, 32'h100, 32'h100, 64'h100);
        add_record(32'hffff, 32'hffff, 32'hffff, 64'hffff);
        add_record(32'h1_0000, 32'h1_0000, 32'h1_0000, 64'h1_0000);
        add_record(32'hffff_ffff, 32'h0, 32'h7f, 64'hffff_ffff);
        add_record(32'h0, 32'h0, 32'h0, 64'h1_0000_0000);
        add_record(32'h1, 32'hab, 32'h1234, 64'h8000_0000_0000_0000);
        add_record(32'hdead_beef, 32'h55, 32'h7f, 64'h0123_4567_89ab_cdef);
        add_record(32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'hc3c3, 64'haaaa_aaaa_5555_5555);
        add_record(32'h8000_0000, 32'h8000, 32'h80, 64'h80);
        add_record(32'h7fff_ffff, 32'h7fff, 32'h7f, 64'h7fff_ffff_ffff_ffff);
        add_record(32'h12, 32'h1_2345, 32'hfe, 64'h0000_0001_0000_0001);

        for (int n = 0; n < RANDOM_RECORDS; n++) begin
            add_record(random_word(), random_word(), random_word(), random_time());
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every record to be taken and every predicted byte to arrive,
        // then watch a little longer for stray bytes.
        while (pending_records.size() != 0 || start || exp_frame_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Encoded %0d records into %0d frames, %0d bytes compared; %0d mismatches.",
                 records_taken, frames_checked, bytes_checked, error_count);
        if (error_count == 0) begin
            $display("msgpack_record_frame_encoder_tb: PASS");
        end else begin
            $display("msgpack_record_frame_encoder_tb: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, where every record waits out
    // the longest gap and then yields a 29-byte frame.
    initial begin
        #(2_000_000);
        $display("Run timed out with %0d bytes still expected.", exp_frame_q.size());
        $display("msgpack_record_frame_encoder_tb: FAIL");
        $finish;
    end

endmodule
